FILE: rtl/core/owtr_pkg.sv
// Shared types, constants and helper functions of the single-wire temperature reader.
`default_nettype none

package owtr_pkg;

    localparam int unsigned DEF_COUNT_WIDTH = 16;
    localparam int unsigned REG_WIDTH       = 16;
    localparam int unsigned CFG_IDX_WIDTH   = 3;
    localparam int unsigned TEMP_WIDTH      = 16;
    localparam int unsigned S_TDATA_WIDTH   = 8;
    localparam int unsigned M_TDATA_WIDTH   = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDLE_TICKS     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RESET_LOW      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRESENCE_WAIT  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SLOT_LOW       = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WRITE_HOLD     = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_READ_SAMPLE    = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_READ_RECOVER   = 3'd6;

    localparam logic [REG_WIDTH-1:0] RST_IDLE_TICKS    = 16'd30;
    localparam logic [REG_WIDTH-1:0] RST_RESET_LOW     = 16'd600;
    localparam logic [REG_WIDTH-1:0] RST_PRESENCE_WAIT = 16'd50;
    localparam logic [REG_WIDTH-1:0] RST_SLOT_LOW      = 16'd30;
    localparam logic [REG_WIDTH-1:0] RST_WRITE_HOLD    = 16'd300;
    localparam logic [REG_WIDTH-1:0] RST_READ_SAMPLE   = 16'd30;
    localparam logic [REG_WIDTH-1:0] RST_READ_RECOVER  = 16'd100;

    // Script steps: reset, skip ROM, convert, reset, skip ROM, read scratchpad, two reads.
    localparam logic [2:0] STEP_FIRST_RESET  = 3'd0;
    localparam logic [2:0] STEP_SECOND_RESET = 3'd3;
    localparam logic [2:0] STEP_FIRST_READ   = 3'd6;
    localparam logic [2:0] STEP_LAST         = 3'd7;
    localparam logic [2:0] BIT_LAST          = 3'd7;

    localparam logic [7:0] CMD_SKIP_ROM    = 8'hCC;
    localparam logic [7:0] CMD_CONVERT     = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPAD = 8'hBE;

    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_RST_REL    = 10'b00_0000_0010,
        PH_RST_LOW    = 10'b00_0000_0100,
        PH_PRES_WAIT  = 10'b00_0000_1000,
        PH_PRES_AFTER = 10'b00_0001_0000,
        PH_W_LOW      = 10'b00_0010_0000,
        PH_W_HOLD     = 10'b00_0100_0000,
        PH_R_LOW      = 10'b00_1000_0000,
        PH_R_SAMPLE   = 10'b01_0000_0000,
        PH_R_REC      = 10'b10_0000_0000
    } t_phase;

    function automatic logic [7:0] script_byte(input logic [2:0] step);
        logic [7:0] b;
        unique case (step)
            3'd1, 3'd4: b = CMD_SKIP_ROM;
            3'd2:       b = CMD_CONVERT;
            3'd5:       b = CMD_READ_SCRPAD;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    // First phase of a script step.
    function automatic t_phase step_entry(input logic [2:0] step);
        t_phase p;
        if (step == STEP_FIRST_RESET || step == STEP_SECOND_RESET) begin
            p = PH_RST_REL;
        end else if (step >= STEP_FIRST_READ) begin
            p = PH_R_LOW;
        end else begin
            p = PH_W_LOW;
        end
        return p;
    endfunction

    // Tenths of a degree from sixteenths: (10*raw + 8) / 16, truncated toward zero.
    function automatic logic signed [TEMP_WIDTH-1:0] to_tenths(
        input logic signed [TEMP_WIDTH-1:0] raw
    );
        logic signed [19:0] ext;
        logic signed [19:0] sum;
        logic signed [19:0] quo;
        ext = 20'(raw);
        sum = (ext <<< 3) + (ext <<< 1) + 20'sd8;
        if (sum < 0) begin
            sum = sum + 20'sd15;
        end
        quo = sum >>> 4;
        return quo[TEMP_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/one_wire_temperature_reader.sv
// Top level of the single-wire bus master that reads a temperature sensor with skip ROM.
//
// Each slave-side transaction is one bus tick: tdata[0] requests a measurement,
// tdata[1] carries the line level sampled in that tick. Each tick yields exactly
// one master-side transaction holding the line drive, busy and done flags and the
// latest reading in sixteenths and in tenths of a degree.
// The script (reset, 0xCC, 0x44, reset, 0xCC, 0xBE, two read bytes) is stepped by a
// tick counter per phase; phase lengths come from the seven configuration registers.
// The result of an accepted tick is registered in the output register,
// and one tick is taken in every cycle, limited only by the output register: a new
// tick is accepted whenever that register is empty or is being emptied in the same
// cycle. When the receiver stalls, the result is held and input is stalled too.
// The configuration channel is always ready; a write to index 7 is ignored.
// Reset returns the sequencer to idle, clears the stored reading, empties the
// output register and loads the default register values.
`default_nettype none

module one_wire_temperature_reader #(
    parameter int unsigned COUNT_WIDTH = owtr_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [0] start_req, [1] line_in, [7:2] zero
    input  wire logic [owtr_pkg::S_TDATA_WIDTH-1:0] i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [0] line_drive_low, [1] busy_res, [2] done_res, [18:3] temp_raw,
    // [34:19] temp_tenths, [39:35] zero
    output logic [owtr_pkg::M_TDATA_WIDTH-1:0]      o_m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [owtr_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [owtr_pkg::REG_WIDTH-1:0]     i_cfg_data
);
    import owtr_pkg::*;

    localparam int unsigned LEN_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
    localparam logic [LEN_WIDTH-1:0] COUNT_MAX = LEN_WIDTH'({COUNT_WIDTH{1'b1}});

    logic [REG_WIDTH-1:0]   r_idle_ticks, r_reset_low, r_presence_wait, r_slot_low;
    logic [REG_WIDTH-1:0]   r_write_hold, r_read_sample, r_read_recover;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [2:0]             r_bit, n_bit;
    logic [2:0]             r_cmd, n_cmd;
    logic [15:0]            r_shift, n_shift;
    logic [15:0]            r_last, n_last;

    logic                   r_out_valid;
    logic                   r_out_drive, r_out_busy, r_out_done;
    logic [TEMP_WIDTH-1:0]  r_out_raw, r_out_tenths;

    logic                   s_fire;
    logic                   start_req, line_in;
    logic                   drive, busy, done;

    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign start_req       = i_s_axis_tdata[0];
    assign line_in         = i_s_axis_tdata[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks    <= RST_IDLE_TICKS;
            r_reset_low     <= RST_RESET_LOW;
            r_presence_wait <= RST_PRESENCE_WAIT;
            r_slot_low      <= RST_SLOT_LOW;
            r_write_hold    <= RST_WRITE_HOLD;
            r_read_sample   <= RST_READ_SAMPLE;
            r_read_recover  <= RST_READ_RECOVER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDLE_TICKS:    r_idle_ticks    <= i_cfg_data;
                CFG_RESET_LOW:     r_reset_low     <= i_cfg_data;
                CFG_PRESENCE_WAIT: r_presence_wait <= i_cfg_data;
                CFG_SLOT_LOW:      r_slot_low      <= i_cfg_data;
                CFG_WRITE_HOLD:    r_write_hold    <= i_cfg_data;
                CFG_READ_SAMPLE:   r_read_sample   <= i_cfg_data;
                CFG_READ_RECOVER:  r_read_recover  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        t_phase                 cur_phase;
        logic [COUNT_WIDTH-1:0] cur_tick;
        logic [2:0]             cur_bit;
        logic [2:0]             cur_cmd;
        logic [15:0]            cur_shift;
        logic [REG_WIDTH-1:0]   len_reg;
        logic [LEN_WIDTH-1:0]   len;
        logic                   last_tick;
        logic                   adv;
        logic [7:0]             wbyte;

        cur_phase = r_phase;
        cur_tick  = r_tick;
        cur_bit   = r_bit;
        cur_cmd   = r_cmd;
        cur_shift = r_shift;
        if (r_phase == PH_IDLE && start_req) begin
            cur_phase = PH_RST_REL;
            cur_tick  = '0;
            cur_bit   = '0;
            cur_cmd   = STEP_FIRST_RESET;
            cur_shift = '0;
        end

        n_phase = cur_phase;
        n_tick  = cur_tick;
        n_bit   = cur_bit;
        n_cmd   = cur_cmd;
        n_shift = cur_shift;
        n_last  = r_last;
        drive   = 1'b0;
        busy    = 1'b0;
        done    = 1'b0;
        adv     = 1'b0;
        wbyte   = script_byte(cur_cmd);

        unique case (cur_phase)
            PH_RST_REL, PH_PRES_AFTER: len_reg = r_idle_ticks;
            PH_RST_LOW:                len_reg = r_reset_low;
            PH_PRES_WAIT:              len_reg = r_presence_wait;
            PH_W_LOW, PH_R_LOW:        len_reg = r_slot_low;
            PH_W_HOLD:                 len_reg = r_write_hold;
            PH_R_SAMPLE:               len_reg = r_read_sample;
            default:                   len_reg = r_read_recover;
        endcase
        // A zero length counts as one tick; lengths beyond the counter are clipped.
        len = (len_reg == '0) ? LEN_WIDTH'(1) : LEN_WIDTH'(len_reg);
        if (len > COUNT_MAX) begin
            len = COUNT_MAX;
        end
        last_tick = ((LEN_WIDTH + 1)'(cur_tick) + (LEN_WIDTH + 1)'(1)) >= (LEN_WIDTH + 1)'(len);

        if (cur_phase != PH_IDLE) begin
            busy = 1'b1;
            if (last_tick) begin
                n_tick = '0;
            end else begin
                n_tick = cur_tick + COUNT_WIDTH'(1);
            end
        end

        unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_RST_REL: begin
                if (last_tick) begin
                    n_phase = PH_RST_LOW;
                end
            end
            PH_RST_LOW: begin
                drive = 1'b1;
                if (last_tick) begin
                    n_phase = PH_PRES_WAIT;
                end
            end
            PH_PRES_WAIT: begin
                // The presence response is not examined.
                if (last_tick) begin
                    n_phase = PH_PRES_AFTER;
                end
            end
            PH_PRES_AFTER: begin
                adv = last_tick;
            end
            PH_W_LOW: begin
                drive = 1'b1;
                if (last_tick) begin
                    n_phase = PH_W_HOLD;
                end
            end
            PH_W_HOLD: begin
                drive = !wbyte[cur_bit];
                if (last_tick) begin
                    if (cur_bit == BIT_LAST) begin
                        adv = 1'b1;
                    end else begin
                        n_bit   = cur_bit + 3'd1;
                        n_phase = PH_W_LOW;
                    end
                end
            end
            PH_R_LOW: begin
                drive = 1'b1;
                if (last_tick) begin
                    n_phase = PH_R_SAMPLE;
                end
            end
            PH_R_SAMPLE: begin
                if (last_tick) begin
                    if (line_in) begin
                        n_shift[{cur_cmd == STEP_LAST, cur_bit}] = 1'b1;
                    end
                    n_phase = PH_R_REC;
                end
            end
            PH_R_REC: begin
                if (last_tick) begin
                    if (cur_bit == BIT_LAST) begin
                        adv = 1'b1;
                    end else begin
                        n_bit   = cur_bit + 3'd1;
                        n_phase = PH_R_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (adv) begin
            n_bit = '0;
            if (cur_cmd == STEP_LAST) begin
                n_last  = n_shift;
                n_cmd   = STEP_FIRST_RESET;
                n_phase = PH_IDLE;
                done    = 1'b1;
            end else begin
                n_cmd   = cur_cmd + 3'd1;
                n_phase = step_entry(cur_cmd + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_cmd       <= '0;
            r_shift     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_cmd       <= n_cmd;
                r_shift     <= n_shift;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_drive  <= drive;
            r_out_busy   <= busy;
            r_out_done   <= done;
            r_out_raw    <= n_last;
            r_out_tenths <= to_tenths(n_last);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_tenths, r_out_raw, r_out_done, r_out_busy,
                              r_out_drive};

    // The sequencer rests with its step and bit counters cleared.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cmd == STEP_FIRST_RESET && r_bit == 3'd0))
        else $error("idle with step or bit counter not cleared");

    // Read slots only occur in the two read steps.
    a_read_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_R_LOW || r_phase == PH_R_SAMPLE || r_phase == PH_R_REC)
        |-> (r_cmd >= STEP_FIRST_READ))
        else $error("read slot outside the read steps");

    // Completion and line drive only happen on ticks that belong to the script.
    a_flags_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_done || r_out_drive)) |-> r_out_busy)
        else $error("done or drive reported outside a running script");

    // Completion always returns the sequencer to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && done) |=> (r_phase == PH_IDLE))
        else $error("script finished but sequencer not idle");

endmodule

`default_nettype wire
